>>> sv/sorted_key_flag_table_assert.svh
// Assertion macros shared by the sorted key flag table modules.
`ifndef SORTED_KEY_FLAG_TABLE_ASSERT_SVH
`define SORTED_KEY_FLAG_TABLE_ASSERT_SVH

// cond holds on every clock edge out of reset
`define SKFT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// trig implies cons in the same cycle
`define SKFT_ASSERT_SAME(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// trig implies cons in the following cycle
`define SKFT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/skft_pkg.sv
// Shared constants, types and command/status structs of the sorted key flag table.
package skft_pkg;

    localparam int DEPTH    = 64;
    localparam int KEY_BITS = 16;
    localparam int FLAG_W   = 16;
    localparam int FIDX_W   = $clog2(FLAG_W);
    localparam int ENTRY_W  = KEY_BITS + FLAG_W;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int POS_W    = 7;

    typedef enum logic [1:0] {
        OP_TEST  = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_RSVD  = 2'd3
    } t_op;

    typedef struct packed {
        logic accept;      // capture request, start search
        logic search_rd;   // read probe entry at mid
        logic search_end;  // search ran out, position is lo
        logic compare;     // evaluate probe read data
        logic mark_full;   // refused insert
        logic shift_up;    // start moving entries up, count + 1
        logic shift_down;  // start moving entries down, count - 1
        logic shift_step;  // one shift step
        logic write;       // write the updated entry at position
        logic load_out;    // load result register
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic lo_lt_hi;
        logic key_eq;
        logic hit;
        logic was_set;
        logic is_full;
        logic flags_zero;
        logic shift_done;
    } t_stat;

endpackage

>>> sv/skft_dp.sv
// Datapath: entry memory, binary search registers, shift pointers, result register.
module skft_dp import skft_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [1:0]          i_op,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [FIDX_W-1:0]   i_flag_index,
    input  t_cmd                i_cmd,
    output t_stat               o_stat,
    output logic                o_found,
    output logic                o_flag_was_set,
    output logic [POS_W-1:0]    o_position,
    output logic                o_table_full,
    output logic [POS_W-1:0]    o_entry_count
);

    logic [ENTRY_W-1:0]  mem [DEPTH];
    logic [ENTRY_W-1:0]  r_rdata;

    t_op                 r_op;
    logic [KEY_BITS-1:0] r_key;
    logic [FLAG_W-1:0]   r_bit;
    logic [FLAG_W-1:0]   r_flags;
    logic                r_hit;
    logic                r_full;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_lo;
    logic [CNT_W-1:0]    r_hi;
    logic [CNT_W-1:0]    r_pos;
    logic [IDX_W-1:0]    r_mid;

    logic [IDX_W-1:0]    r_rd_ptr;
    logic [IDX_W-1:0]    r_wr_ptr;
    logic [CNT_W-1:0]    r_left;
    logic                r_wr_pend;
    logic                r_up;

    logic                r_o_found;
    logic                r_o_was_set;
    logic [POS_W-1:0]    r_o_pos;
    logic                r_o_full;
    logic [POS_W-1:0]    r_o_count;

    logic [CNT_W:0]      mid_sum;
    logic [IDX_W-1:0]    mid;
    logic [KEY_BITS-1:0] probe_key;
    logic                was_set;
    logic [FLAG_W-1:0]   new_flags;
    logic [ENTRY_W-1:0]  new_entry;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    logic [ENTRY_W-1:0]  mem_wd;
    logic                mem_re;
    logic [IDX_W-1:0]    mem_ra;
    logic                rd_more;

    // mid < hi <= DEPTH, so it fits an index
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = IDX_W'(mid_sum[CNT_W:1]);
    assign probe_key = r_rdata[ENTRY_W-1 -: KEY_BITS];
    assign was_set   = r_hit && ((r_flags & r_bit) != '0);
    assign new_flags = (r_op == OP_SET) ? (r_flags | r_bit) : (r_flags & ~r_bit);
    assign new_entry = r_hit ? {r_key, new_flags} : {r_key, r_bit};
    assign rd_more   = (r_left != '0);

    always_comb begin
        mem_we = i_cmd.write || (i_cmd.shift_step && r_wr_pend);
        mem_wa = i_cmd.write ? IDX_W'(r_pos) : r_wr_ptr;
        mem_wd = i_cmd.write ? new_entry : r_rdata;
        mem_re = i_cmd.search_rd || (i_cmd.shift_step && rd_more);
        mem_ra = i_cmd.search_rd ? mid : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= mem[mem_ra];
        end
    end

    // request capture and search
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo  <= '0;
            r_hi  <= '0;
            r_hit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_lo  <= '0;
            r_hi  <= r_count;
            r_hit <= 1'b0;
        end else if (i_cmd.compare) begin
            if (probe_key == r_key) begin
                r_hit <= 1'b1;
            end else if (r_key > probe_key) begin
                r_lo <= CNT_W'(r_mid) + CNT_W'(1);
            end else begin
                r_hi <= CNT_W'(r_mid);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op  <= t_op'(i_op);
            r_key <= i_key;
            r_bit <= FLAG_W'(1) << i_flag_index;
        end
        if (i_cmd.search_rd) begin
            r_mid <= mid;
        end
        if (i_cmd.search_end) begin
            r_pos <= r_lo;
        end
        if (i_cmd.compare && (probe_key == r_key)) begin
            r_pos   <= CNT_W'(r_mid);
            r_flags <= r_rdata[FLAG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_cmd.accept) begin
            r_full <= 1'b0;
        end else if (i_cmd.mark_full) begin
            r_full <= 1'b1;
        end
    end

    // entry count and shift engine; one entry moves per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_left    <= '0;
            r_wr_pend <= 1'b0;
        end else if (i_cmd.shift_up) begin
            r_count   <= r_count + CNT_W'(1);
            r_up      <= 1'b1;
            r_rd_ptr  <= IDX_W'(r_count - CNT_W'(1));
            r_left    <= r_count - r_pos;
            r_wr_pend <= 1'b0;
        end else if (i_cmd.shift_down) begin
            r_count   <= r_count - CNT_W'(1);
            r_up      <= 1'b0;
            r_rd_ptr  <= IDX_W'(r_pos + CNT_W'(1));
            r_left    <= r_count - r_pos - CNT_W'(1);
            r_wr_pend <= 1'b0;
        end else if (i_cmd.shift_step) begin
            r_wr_pend <= rd_more;
            if (rd_more) begin
                r_left   <= r_left - CNT_W'(1);
                r_wr_ptr <= r_up ? (r_rd_ptr + IDX_W'(1)) : (r_rd_ptr - IDX_W'(1));
                r_rd_ptr <= r_up ? (r_rd_ptr - IDX_W'(1)) : (r_rd_ptr + IDX_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_found   <= r_hit;
            r_o_was_set <= was_set;
            r_o_pos     <= POS_W'(r_pos);
            r_o_full    <= r_full;
            r_o_count   <= POS_W'(r_count);
        end
    end

    always_comb begin
        o_stat.op         = r_op;
        o_stat.lo_lt_hi   = (r_lo < r_hi);
        o_stat.key_eq     = (probe_key == r_key);
        o_stat.hit        = r_hit;
        o_stat.was_set    = was_set;
        o_stat.is_full    = (r_count >= CNT_W'(DEPTH));
        o_stat.flags_zero = ((r_flags & ~r_bit) == '0);
        o_stat.shift_done = !rd_more && !r_wr_pend;
    end

    assign o_found        = r_o_found;
    assign o_flag_was_set = r_o_was_set;
    assign o_position     = r_o_pos;
    assign o_table_full   = r_o_full;
    assign o_entry_count  = r_o_count;

`include "sorted_key_flag_table_assert.svh"

    `SKFT_ASSERT_ALWAYS(a_count_max, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `SKFT_ASSERT_ALWAYS(a_search_window, r_lo <= r_hi, "search window inverted")
    `SKFT_ASSERT_SAME(a_shift_in_range, r_wr_pend, CNT_W'(r_wr_ptr) < r_count, "shift write past end")

endmodule

>>> sv/skft_ctrl.sv
// Controller: sequences search, decision, shift, write and result handoff.
module skft_ctrl import skft_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_SEARCH  = 7'b0000010,
        ST_COMPARE = 7'b0000100,
        ST_DECIDE  = 7'b0001000,
        ST_SHIFT   = 7'b0010000,
        ST_WRITE   = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.search_rd = 1'b1;
                    n_state         = ST_COMPARE;
                end else begin
                    o_cmd.search_end = 1'b1;
                    n_state          = ST_DECIDE;
                end
            end
            ST_COMPARE: begin
                o_cmd.compare = 1'b1;
                n_state       = i_stat.key_eq ? ST_DECIDE : ST_SEARCH;
            end
            ST_DECIDE: begin
                unique case (i_stat.op)
                    OP_SET: begin
                        priority if (i_stat.hit) begin
                            n_state = ST_WRITE;
                        end else if (i_stat.is_full) begin
                            o_cmd.mark_full = 1'b1;
                            n_state         = ST_FINISH;
                        end else begin
                            o_cmd.shift_up = 1'b1;
                            n_state        = ST_SHIFT;
                        end
                    end
                    OP_CLEAR: begin
                        priority if (!i_stat.was_set) begin
                            n_state = ST_FINISH;
                        end else if (!i_stat.flags_zero) begin
                            n_state = ST_WRITE;
                        end else begin
                            o_cmd.shift_down = 1'b1;
                            n_state          = ST_SHIFT;
                        end
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT: begin
                o_cmd.shift_step = 1'b1;
                if (i_stat.shift_done) begin
                    // insert still owes the new entry; delete is complete
                    n_state = (i_stat.op == OP_SET) ? ST_WRITE : ST_FINISH;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`include "sorted_key_flag_table_assert.svh"

    `SKFT_ASSERT_NEXT(a_accept_starts, i_in_valid && !o_in_stall, r_state == ST_SEARCH, "accept did not start search")
    `SKFT_ASSERT_NEXT(a_finish_loads, r_state == ST_FINISH && out_free, r_out_valid && r_state == ST_IDLE, "result not loaded")
    `SKFT_ASSERT_SAME(a_shift_only_edit, o_cmd.shift_step, i_stat.op == OP_SET || i_stat.op == OP_CLEAR, "shift on read-only op")

endmodule

>>> sv/sorted_key_flag_table.sv
// Top level of the sorted key flag table: controller plus datapath.
//
// Keeps up to 64 entries in a memory with one read and one write port, sorted
// ascending by a 16-bit key, each entry carrying 16 flag bits. A request (op,
// key, flag_index) is taken only while the block is idle; o_in_stall is high for
// the whole time a request is being worked. The key is located by binary search,
// each probe being a memory read, then a compare. Set on a missing key inserts
// at the sorted position; clear of the last set flag deletes the entry. Either
// one moves every later entry by one slot, one entry per cycle (the read of one
// slot overlaps the write of the one before), followed by the write of an
// inserted entry. Test (and the unused op code) only reports. A refused insert
// on a full table leaves the table unchanged and sets o_table_full. Each
// request yields exactly one result transfer; the result sits in an output
// register, so the block starts on the next request while that result waits,
// and holds its final step only while an earlier result is still stalled.
// Entry memory needs no clearing after reset: only entries below the entry
// count are ever read.
module sorted_key_flag_table import skft_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_op,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic [FIDX_W-1:0]   i_flag_index,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_found,
    output logic                o_flag_was_set,
    output logic [POS_W-1:0]    o_position,
    output logic                o_table_full,
    output logic [POS_W-1:0]    o_entry_count
);

    t_cmd  cmd;
    t_stat stat;

    // sequencing only; no payload passes through here
    skft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // table memory, search window, shift pointers and result register
    skft_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_flag_index   (i_flag_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_found        (o_found),
        .o_flag_was_set (o_flag_was_set),
        .o_position     (o_position),
        .o_table_full   (o_table_full),
        .o_entry_count  (o_entry_count)
    );

endmodule

>>> bench/tb_sorted_key_flag_table.sv
// Self-checking bench for the sorted key flag table: directed and episode-based random requests.
module tb_sorted_key_flag_table;
    import skft_pkg::*;

    localparam int N_ITEMS      = 1150;  // random requests, roughly
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 200;   // wait after the last reply before the verdict

    // One queued request. A hold entry is not sent: the sender waits at it
    // until every outstanding reply has come back.
    typedef struct packed {
        logic                hold;
        t_op                 op;
        logic [KEY_BITS-1:0] key;
        logic [FIDX_W-1:0]   fidx;
    } req_t;

    // Reply fields in port order.
    typedef struct packed {
        logic             found;
        logic             was_set;
        logic [POS_W-1:0] position;
        logic             full;
        logic [POS_W-1:0] count;
    } resp_t;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_in_valid   = 1'b0;
    logic                o_in_stall;
    logic [1:0]          i_op         = '0;
    logic [KEY_BITS-1:0] i_key        = '0;
    logic [FIDX_W-1:0]   i_flag_index = '0;
    logic                o_out_valid;
    logic                i_out_stall  = 1'b0;
    logic                o_found;
    logic                o_flag_was_set;
    logic [POS_W-1:0]    o_position;
    logic                o_table_full;
    logic [POS_W-1:0]    o_entry_count;

    sorted_key_flag_table dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_key          (i_key),
        .i_flag_index   (i_flag_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_found        (o_found),
        .o_flag_was_set (o_flag_was_set),
        .o_position     (o_position),
        .o_table_full   (o_table_full),
        .o_entry_count  (o_entry_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shadow table: sorted keys with their flag words, plus the entry count.
    // ------------------------------------------------------------------
    logic [KEY_BITS-1:0] tbl_key   [DEPTH];
    logic [FLAG_W-1:0]   tbl_flags [DEPTH];
    int                  tbl_count = 0;

    req_t  queued_requests [$];
    resp_t pending_replies [$];
    int    err_count    = 0;
    int    quiet_cycles = 0;

    // Applies one accepted request to the shadow table and returns the reply
    // it must produce. Keys are unique and sorted, so the first slot whose key
    // is not below the request key is both the hit index and the insert point.
    function automatic resp_t apply_request(input t_op op, input logic [KEY_BITS-1:0] key,
                                            input logic [FIDX_W-1:0] fidx);
        resp_t             r;
        int                pos;
        logic              hit;
        logic [FLAG_W-1:0] bit_mask;
        pos = 0;
        while (pos < tbl_count && tbl_key[pos] < key)
            pos++;
        hit      = (pos < tbl_count) && (tbl_key[pos] == key);
        bit_mask = FLAG_W'(1) << fidx;
        r          = '0;
        r.found    = hit;
        r.was_set  = hit && ((tbl_flags[pos] & bit_mask) != '0);
        r.position = POS_W'(pos);
        case (op)
            OP_SET: begin
                if (hit) begin
                    tbl_flags[pos] |= bit_mask;
                end else if (tbl_count >= DEPTH) begin
                    r.full = 1'b1;                    // refused insert, table untouched
                end else begin
                    for (int i = tbl_count; i > pos; i--) begin
                        tbl_key[i]   = tbl_key[i-1];
                        tbl_flags[i] = tbl_flags[i-1];
                    end
                    tbl_key[pos]   = key;
                    tbl_flags[pos] = bit_mask;
                    tbl_count++;
                end
            end
            OP_CLEAR: begin
                if (r.was_set) begin
                    tbl_flags[pos] &= ~bit_mask;
                    if (tbl_flags[pos] == '0) begin   // last flag gone: delete entry
                        for (int i = pos; i < tbl_count - 1; i++) begin
                            tbl_key[i]   = tbl_key[i+1];
                            tbl_flags[i] = tbl_flags[i+1];
                        end
                        tbl_count--;
                    end
                end
            end
            default: ;                                // test and the spare code only report
        endcase
        r.count = POS_W'(tbl_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation. Every (key, flag) that a set may have turned on is
    // remembered, so a drain episode can clear all of them and empty the table.
    // ------------------------------------------------------------------
    bit                  set_pairs [bit [KEY_BITS+FIDX_W-1:0]];
    logic [KEY_BITS-1:0] live_keys [$];
    int                  gen_count = 0;

    function automatic void push_req(input t_op op, input logic [KEY_BITS-1:0] key,
                                     input logic [FIDX_W-1:0] fidx);
        queued_requests.push_back('{1'b0, op, key, fidx});
        gen_count++;
        if (op == OP_SET) begin
            set_pairs[{key, fidx}] = 1'b1;
            live_keys.push_back(key);
        end
    endfunction

    function automatic void push_hold();
        queued_requests.push_back('{1'b1, OP_TEST, '0, '0});
    endfunction

    function automatic void push_batch(ref req_t batch[$]);
        int   j;
        req_t t;
        for (int i = batch.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            t        = batch[i];
            batch[i] = batch[j];
            batch[j] = t;
        end
        foreach (batch[i])
            push_req(batch[i].op, batch[i].key, batch[i].fidx);
    endfunction

    // Sets one to three flags on each of n_keys keys, in random order; with spread 0 or 1 a key
    // sometimes gets one more request of a random op. spread: 0 anywhere, 1 clustered in a
    // narrow window, 2 distinct keys strictly between 0 and 0xffff (used to force a full table).
    function automatic void fill_keys(input int n_keys, input int spread, input int flag_top);
        req_t                batch [$];
        logic [KEY_BITS-1:0] base;
        logic [KEY_BITS-1:0] k;
        int                  stride;
        base   = KEY_BITS'($urandom_range(0, 65535 - 4 * n_keys));
        stride = 65000 / n_keys;
        for (int i = 0; i < n_keys; i++) begin
            case (spread)
                0:       k = KEY_BITS'($urandom);
                1:       k = base + KEY_BITS'($urandom_range(0, 3 * n_keys));
                default: k = KEY_BITS'(1 + i * stride + $urandom_range(0, stride - 1));
            endcase
            repeat ($urandom_range(1, 3))
                batch.push_back('{1'b0, OP_SET, k, FIDX_W'($urandom_range(0, flag_top))});
            if (spread != 2 && $urandom_range(0, 3) == 0)
                batch.push_back('{1'b0, t_op'($urandom_range(0, 3)), k, FIDX_W'($urandom)});
        end
        push_batch(batch);
    endfunction

    // Clears every flag that may be on, with a few lookups mixed in.
    function automatic void drain_all();
        req_t batch [$];
        foreach (set_pairs[p]) begin
            batch.push_back('{1'b0, OP_CLEAR, p[KEY_BITS+FIDX_W-1:FIDX_W], p[FIDX_W-1:0]});
            if ($urandom_range(0, 5) == 0)
                batch.push_back('{1'b0, OP_TEST, p[KEY_BITS+FIDX_W-1:FIDX_W],
                                  FIDX_W'($urandom)});
        end
        push_batch(batch);
        set_pairs.delete();
        live_keys.delete();
    endfunction

    // Unstructured traffic: any op, half the keys taken from ones set before.
    function automatic void noise(input int n);
        logic [KEY_BITS-1:0] k;
        for (int i = 0; i < n; i++) begin
            if (live_keys.size() != 0 && $urandom_range(0, 1) == 0)
                k = live_keys[$urandom_range(0, live_keys.size() - 1)];
            else
                k = KEY_BITS'($urandom);
            push_req(t_op'($urandom_range(0, 3)), k, FIDX_W'($urandom));
        end
    endfunction

    // ------------------------------------------------------------------
    // Request driver. Inputs change only at the clock edge, by nonblocking
    // assignment. On each transfer the shadow table is updated and the reply
    // queued; the next request follows after a drawn gap. Gap size runs in
    // bursts: some stretches never idle, others idle between requests.
    // ------------------------------------------------------------------
    int   send_gap   = 0;
    int   send_max   = 0;
    int   send_burst = 0;
    req_t nxt;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                pending_replies.push_back(apply_request(t_op'(i_op), i_key, i_flag_index));
                send_burst = send_burst - 1;
                if (send_burst <= 0) begin
                    send_burst = $urandom_range(20, 120);
                    send_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
                end
                send_gap = $urandom_range(0, send_max);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (queued_requests.size() != 0 && queued_requests[0].hold) begin
                    // pause until the block has returned everything
                    if (pending_replies.size() == 0 && !o_out_valid)
                        void'(queued_requests.pop_front());
                    i_in_valid <= 1'b0;
                end else if (queued_requests.size() != 0) begin
                    nxt = queued_requests.pop_front();
                    i_op         <= nxt.op;
                    i_key        <= nxt.key;
                    i_flag_index <= nxt.fidx;
                    i_in_valid   <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Reply monitor: checks each transfer against the oldest queued reply,
    // then stalls for a drawn number of cycles, also in bursts.
    // ------------------------------------------------------------------
    int    stall_left  = 0;
    int    stall_max   = 0;
    int    stall_burst = 0;
    resp_t want;
    resp_t got;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left  = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                got = '{o_found, o_flag_was_set, o_position, o_table_full, o_entry_count};
                if (pending_replies.size() == 0) begin
                    err_count++;
                    $display("%0t: reply with nothing outstanding:", $time,
                             " found=%0d was_set=%0d pos=%0d", got.found, got.was_set,
                             got.position, " full=%0d count=%0d", got.full, got.count);
                end else begin
                    want = pending_replies.pop_front();
                    if (got !== want) begin
                        err_count++;
                        $display("%0t: reply mismatch, expected", $time,
                                 " found=%0d was_set=%0d pos=%0d", want.found,
                                 want.was_set, want.position,
                                 " full=%0d count=%0d", want.full, want.count);
                        $display("%0t:                 actual", $time,
                                 " found=%0d was_set=%0d pos=%0d", got.found,
                                 got.was_set, got.position,
                                 " full=%0d count=%0d", got.full, got.count);
                    end
                end
                stall_burst = stall_burst - 1;
                if (stall_burst <= 0) begin
                    stall_burst = $urandom_range(20, 120);
                    stall_max   = ($urandom_range(0, 2) == 0) ? 0 : 10;
                end
                stall_left = $urandom_range(0, stall_max);
            end else if (stall_left > 0) begin
                stall_left = stall_left - 1;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    // Watchdog: any transfer on either side restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("FAIL sorted_key_flag_table");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        // directed: empty table, inserts into empty table/front/end, repeated set,
        // spare op code, clear of an off flag, deletes at middle/front/last
        push_req(OP_TEST,  16'h0000, 4'd0);
        push_req(OP_CLEAR, 16'hffff, 4'd15);   // clear on missing key
        push_req(OP_SET,   16'h8000, 4'd0);
        push_req(OP_SET,   16'h0000, 4'd15);   // insert at front
        push_req(OP_SET,   16'hffff, 4'd7);    // append
        push_req(OP_SET,   16'h8000, 4'd0);    // flag already on
        push_req(OP_SET,   16'h8000, 4'd15);
        push_req(OP_TEST,  16'h8000, 4'd15);
        push_req(OP_TEST,  16'h8000, 4'd3);
        push_req(OP_RSVD,  16'hffff, 4'd7);    // spare code acts as test
        push_req(OP_RSVD,  16'h1234, 4'd8);
        push_req(OP_CLEAR, 16'h8000, 4'd3);    // flag already off
        push_req(OP_CLEAR, 16'h8000, 4'd0);    // another flag stays on
        push_req(OP_TEST,  16'h7fff, 4'd5);
        push_req(OP_CLEAR, 16'h8000, 4'd15);   // delete in the middle
        push_req(OP_CLEAR, 16'h0000, 4'd15);   // delete at front
        push_req(OP_TEST,  16'h5555, 4'd10);
        push_req(OP_CLEAR, 16'hffff, 4'd7);    // delete last, table empty
        push_req(OP_TEST,  16'haaaa, 4'd5);
        push_hold();

        // fill past capacity, then refused inserts at both ends of the order
        fill_keys(72, 2, 15);
        push_req(OP_SET,   16'h0000, 4'd1);
        push_req(OP_SET,   16'hffff, 4'd14);
        push_req(OP_TEST,  16'hffff, 4'd14);
        push_req(OP_CLEAR, 16'h0000, 4'd1);
        drain_all();

        while (gen_count < N_ITEMS) begin
            case ($urandom_range(0, 5))
                0:       fill_keys($urandom_range(60, 80), 2, 15);
                1, 2:    fill_keys($urandom_range(2, 30), $urandom_range(0, 1),
                                   ($urandom_range(0, 3) == 0) ? 15 : 1);
                3:       drain_all();
                4:       noise($urandom_range(10, 40));
                default: begin
                    push_hold();
                    drain_all();
                end
            endcase
        end
        drain_all();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (queued_requests.size() != 0 || i_in_valid || pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0 && pending_replies.size() == 0)
            $display("PASS sorted_key_flag_table");
        else
            $display("FAIL sorted_key_flag_table");
        $finish;
    end

endmodule
